FILE: hdl/vrt_pkg.sv
package vrt_pkg;

   // Q16.16 one.
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   // Configuration register indexes.
   localparam logic CSR_TARGET_TEMP = 1'b0;
   localparam logic CSR_BOLTZMANN   = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_SUMSQ,
      ST_TERM,
      ST_ACC,
      ST_DECIDE,
      ST_NUM_P,
      ST_NUM_C,
      ST_NUM_ADD,
      ST_DIV,
      ST_SQRT,
      ST_RD,
      ST_MAG,
      ST_FIN,
      ST_OUT
   } state_type;

endpackage

FILE: hdl/velocity_rescale_thermostat_unit.sv
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: vel_x, vel_y, vel_z, atom_mass; tlast: last_atom
// rsp      out  rsp_tvalid/rsp_tready  tdata: scaled_x, scaled_y, scaled_z; tlast: last_result;
//                                      tuser: zero_energy
// csr      in   csr_we                 csr_addr, csr_wdata
//
// Each atom's velocity is written to the store on accept when there is room, and its kinetic
// term is built in a four-step multiply and accumulate sequence. On the last atom with a
// nonzero energy sum, the scale comes from a 64-step restoring divide, skipped if the quotient
// would overflow, and a 32-step square root that share the sequencer. Each result then passes
// a store read, a multiply and a round/saturate step and is held until rsp_tready.
// Reset is synchronous; the velocity store is not cleared and needs no clearing pass.
// No new atom is accepted while the scale is computed or results are delivered.
module velocity_rescale_thermostat_unit #(
   parameter int MAX_ATOMS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // vel_x, vel_y, vel_z, atom_mass
   input  logic          req_tlast,   // last_atom
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata,   // scaled_x, scaled_y, scaled_z
   output logic          rsp_tlast,   // last_result
   output logic          rsp_tuser,   // zero_energy
   input  logic          csr_we,
   input  logic          csr_addr,
   input  logic [31:0]   csr_wdata
);
   import vrt_pkg::*;

   localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int CW = $clog2(MAX_ATOMS + 1);

   state_type state_ff, state_in;

   logic [31:0]    temp_ff, kb_ff;
   logic [95:0]    mem [MAX_ATOMS];
   logic [95:0]    rd_data_ff;
   logic [CW-1:0]  count_ff, k_ff;
   logic [63:0]    sum_ff;
   logic           last_ff, zero_ff;
   logic [31:0]    ax_ff, ay_ff, az_ff, mass_ff;
   logic [63:0]    sqx_ff, sqy_ff, sqz_ff, s_ff;
   logic [63:0]    thi_ff, tlo_ff;
   logic [63:0]    p_ff;
   logic [72:0]    a_ff, b_ff;
   logic [63:0]    rem_ff, dlo_ff, q_ff;
   logic [63:0]    x_ff, res_ff, bit_ff;
   logic [5:0]     iter_ff;
   logic [31:0]    scale_ff;
   logic [63:0]    px_ff, py_ff, pz_ff;
   logic [2:0]     neg_ff;
   logic [95:0]    out_data_ff;
   logic           out_last_ff;

   logic           accept, room;
   logic [88:0]    num;
   logic [64:0]    rem_sh, sum_add;
   logic [63:0]    sq_t;
   logic [63:0]    term;
   logic [63:0]    res_next;
   logic [CW+1:0]  n3;
   logic           div_sat;

   // Magnitude of a signed 32-bit word.
   function automatic logic [31:0] mag32(input logic [31:0] v);
      logic [31:0] r;
      r = v[31] ? (~v + 32'd1) : v;
      return r;
   endfunction

   // Round toward minus infinity and saturate one scaled component.
   function automatic logic [31:0] finish(input logic [63:0] prod, input logic neg);
      logic [48:0] q;
      logic [31:0] r;
      q = {1'b0, prod[63:16]};
      if (neg) begin
         if (prod[15:0] != 16'd0) q = q + 49'd1;
         if (q > 49'h0_8000_0000) q = 49'h0_8000_0000;
         r = 32'd0 - q[31:0];
      end else begin
         if (q > 49'h0_7FFF_FFFF) q = 49'h0_7FFF_FFFF;
         r = q[31:0];
      end
      return r;
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign room       = (count_ff < CW'(MAX_ATOMS));
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = zero_ff;

   // Kinetic term is floor(speed^2 * mass / 2^32) from the two partial products.
   assign term     = thi_ff + (tlo_ff >> 32);
   assign n3       = (CW+2)'(3) * {2'b00, count_ff};
   assign num      = {b_ff, 16'd0} + {a_ff[72:0], 16'd0};
   assign div_sat  = ({39'd0, num[88:64]} >= sum_ff);
   assign rem_sh   = {rem_ff, dlo_ff[63]};
   assign sum_add  = {1'b0, sum_ff} + {1'b0, term};
   assign sq_t     = res_ff + bit_ff;
   assign res_next = (x_ff >= sq_t) ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (accept) state_in = room ? ST_SQ : (req_tlast ? ST_DECIDE : ST_IDLE);
         ST_SQ:      state_in = ST_SUMSQ;
         ST_SUMSQ:   state_in = ST_TERM;
         ST_TERM:    state_in = ST_ACC;
         ST_ACC:     state_in = last_ff ? ST_DECIDE : ST_IDLE;
         ST_DECIDE:  begin
            if (count_ff == '0) state_in = ST_IDLE;
            else if (sum_ff == 64'd0) state_in = ST_RD;
            else state_in = ST_NUM_P;
         end
         ST_NUM_P:   state_in = ST_NUM_C;
         ST_NUM_C:   state_in = ST_NUM_ADD;
         ST_NUM_ADD: state_in = div_sat ? ST_SQRT : ST_DIV;
         ST_DIV:     if (iter_ff == 6'd0) state_in = ST_SQRT;
         ST_SQRT:    if (iter_ff == 6'd0) state_in = ST_RD;
         ST_RD:      state_in = ST_MAG;
         ST_MAG:     state_in = ST_FIN;
         ST_FIN:     state_in = ST_OUT;
         ST_OUT:     if (rsp_tready) state_in = out_last_ff ? ST_IDLE : ST_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // Velocity store: written on accept with room; read at k_ff, stepped per delivered word.
   always_ff @(posedge clock) begin
      if (accept && room) mem[count_ff[AW-1:0]] <= req_tdata[95:0];
      rd_data_ff <= mem[k_ff[AW-1:0]];
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff  <= ONE_Q16;
         kb_ff    <= ONE_Q16;
         count_ff <= '0;
         sum_ff   <= 64'd0;
         scale_ff <= ONE_Q16;
         zero_ff  <= 1'b0;
         k_ff     <= '0;
         iter_ff  <= 6'd0;
         last_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_TARGET_TEMP: temp_ff <= csr_wdata;
               CSR_BOLTZMANN:   kb_ff   <= csr_wdata;
               default:         ;
            endcase
         end
         case (state_ff)
            ST_IDLE: if (accept) begin
               last_ff <= req_tlast;
               if (room) count_ff <= count_ff + CW'(1);
            end
            ST_ACC: sum_ff <= sum_add[64] ? '1 : sum_add[63:0];
            ST_DECIDE: begin
               k_ff    <= '0;
               zero_ff <= (sum_ff == 64'd0);
               if (sum_ff == 64'd0) scale_ff <= ONE_Q16;
               if (count_ff == '0) sum_ff <= 64'd0;
            end
            ST_NUM_ADD: iter_ff <= div_sat ? 6'd31 : 6'd63;
            ST_DIV: iter_ff <= (iter_ff == 6'd0) ? 6'd31 : iter_ff - 6'd1;
            ST_SQRT: begin
               iter_ff <= iter_ff - 6'd1;
               if (iter_ff == 6'd0) scale_ff <= res_next[31:0];
            end
            ST_OUT: if (rsp_tready) begin
               k_ff <= k_ff + CW'(1);
               if (out_last_ff) begin
                  count_ff <= '0;
                  sum_ff   <= 64'd0;
               end
            end
            default: ;
         endcase
      end
   end

   // Datapath: kinetic term, numerator, divide, root and output scaling.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            ax_ff   <= mag32(req_tdata[31:0]);
            ay_ff   <= mag32(req_tdata[63:32]);
            az_ff   <= mag32(req_tdata[95:64]);
            mass_ff <= req_tdata[127:96];
         end
         ST_SQ: begin
            sqx_ff <= 64'(ax_ff) * 64'(ax_ff);
            sqy_ff <= 64'(ay_ff) * 64'(ay_ff);
            sqz_ff <= 64'(az_ff) * 64'(az_ff);
         end
         ST_SUMSQ: s_ff <= sqx_ff + sqy_ff + sqz_ff;
         ST_TERM: begin
            thi_ff <= 64'(s_ff[63:32]) * 64'(mass_ff);
            tlo_ff <= 64'(s_ff[31:0]) * 64'(mass_ff);
         end
         ST_NUM_P: p_ff <= 64'(temp_ff) * 64'(kb_ff);
         ST_NUM_C: begin
            a_ff <= 73'(p_ff[31:0]) * 73'(n3);
            b_ff <= (73'(p_ff[63:32]) * 73'(n3)) << 32;
         end
         ST_NUM_ADD: begin
            rem_ff <= {39'd0, num[88:64]};
            dlo_ff <= num[63:0];
            q_ff   <= 64'd0;
            x_ff   <= '1;
            res_ff <= 64'd0;
            bit_ff <= 64'h4000_0000_0000_0000;
         end
         ST_DIV: begin
            dlo_ff <= dlo_ff << 1;
            if (rem_sh >= {1'b0, sum_ff}) begin
               rem_ff <= 64'(rem_sh - {1'b0, sum_ff});
               q_ff   <= {q_ff[62:0], 1'b1};
               if (iter_ff == 6'd0) x_ff <= {q_ff[62:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[63:0];
               q_ff   <= {q_ff[62:0], 1'b0};
               if (iter_ff == 6'd0) x_ff <= {q_ff[62:0], 1'b0};
            end
         end
         ST_SQRT: begin
            bit_ff <= bit_ff >> 2;
            res_ff <= res_next;
            if (x_ff >= sq_t) x_ff <= x_ff - sq_t;
         end
         ST_MAG: begin
            px_ff  <= 64'(mag32(rd_data_ff[31:0])) * 64'(scale_ff);
            py_ff  <= 64'(mag32(rd_data_ff[63:32])) * 64'(scale_ff);
            pz_ff  <= 64'(mag32(rd_data_ff[95:64])) * 64'(scale_ff);
            neg_ff <= {rd_data_ff[95], rd_data_ff[63], rd_data_ff[31]};
         end
         ST_FIN: begin
            out_last_ff <= (k_ff + CW'(1) == count_ff);
            if (zero_ff) out_data_ff <= rd_data_ff;
            else out_data_ff <= {finish(pz_ff, neg_ff[2]), finish(py_ff, neg_ff[1]),
                                 finish(px_ff, neg_ff[0])};
         end
         default: ;
      endcase
   end

   // Input and output never handshake in the same cycle.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input open during read-out");

   // After the final word the block takes atoms again with a fresh count.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && count_ff == '0)
      else $error("set not closed after last word");

   // Unscaled words carry a unit scale.
   a_zero_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> scale_ff == ONE_Q16) else $error("zero-energy scale");

endmodule
